@@ rtl/dmrtx_pkg.sv @@
// dmrtx_pkg: shared types and constants for the direct mode transmit framer
// no dependencies
`default_nettype none
package dmrtx_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'h5F;
  localparam int         FILL_LEN  = 39;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LEN   = 2'd1,
    ST_SPACE = 2'd2
  } wr_status_t;

  typedef enum logic [1:0] {
    CFG_PREAMBLE = 2'd0,
    CFG_CAL_EN   = 2'd1,
    CFG_CAL_PAT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMMIT,
    S_LOAD,
    S_BIT,
    S_RESULT
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic take_item;     // latch input item
    logic stage_byte;    // store a mode 0 byte
    logic commit_step;   // move one staged byte to fifo
    logic commit_done;   // clear staging after last byte
    logic load_step;     // move one fifo byte to out buffer
    logic load_start;    // choose next output buffer
    logic bit_step;      // produce serial bit
    logic set_status;    // latch frame status
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       mode;
    logic       last;
    logic       commit_ok;   // length and space checks passed
    logic       need_load;   // bit request at byte boundary with empty buffer
    logic       load_fifo;   // new buffer comes from the fifo
    logic       cnt_end;     // byte loop counter at its end
  } dp_stat_t;

  localparam logic [7:0] FILL_PATTERN [FILL_LEN] = '{
    8'h63, 8'hEA, 8'h00, 8'h76, 8'h6C, 8'h76, 8'hC4, 8'h52, 8'hC8, 8'h78,
    8'h09, 8'h2D, 8'hB8, 8'h79, 8'h27, 8'h57, 8'h9B, 8'h31, 8'hBC, 8'h3E,
    8'hEA, 8'h45, 8'hC3, 8'h30, 8'h49, 8'h17, 8'h93, 8'hAE, 8'h8B, 8'h6D,
    8'hA4, 8'hA5, 8'hAD, 8'hA2, 8'hF1, 8'h35, 8'hB5, 8'h3C, 8'h1E};

endpackage
`default_nettype wire

@@ rtl/dmrtx_ctrl.sv @@
// dmrtx_ctrl: sequencer for frame commit, buffer load and bit requests
// depends on dmrtx_pkg
`default_nettype none
module dmrtx_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  input  dmrtx_pkg::dp_stat_t   stat,
  output dmrtx_pkg::dp_cmd_t    cmd
);

  dmrtx_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmrtx_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      dmrtx_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take_item = 1'b1;
          state_nxt     = dmrtx_pkg::S_LOAD;
        end
      end
      dmrtx_pkg::S_LOAD: begin
        // decode the latched item
        if (!stat.mode) begin
          cmd.stage_byte = 1'b1;
          state_nxt = stat.last ? dmrtx_pkg::S_COMMIT : dmrtx_pkg::S_IDLE;
        end else if (stat.need_load) begin
          cmd.load_start = 1'b1;
          state_nxt = stat.load_fifo ? dmrtx_pkg::S_COMMIT : dmrtx_pkg::S_BIT;
        end else begin
          state_nxt = dmrtx_pkg::S_BIT;
        end
      end
      dmrtx_pkg::S_COMMIT: begin
        // byte loop: fifo commit for mode 0, out buffer fill for mode 1
        if (!stat.mode) begin
          if (!stat.commit_ok) begin
            cmd.commit_done = 1'b1;
            cmd.set_status  = 1'b1;
            state_nxt       = dmrtx_pkg::S_RESULT;
          end else begin
            cmd.commit_step = 1'b1;
            if (stat.cnt_end) begin
              cmd.commit_done = 1'b1;
              cmd.set_status  = 1'b1;
              state_nxt       = dmrtx_pkg::S_RESULT;
            end
          end
        end else begin
          cmd.load_step = 1'b1;
          if (stat.cnt_end) state_nxt = dmrtx_pkg::S_BIT;
        end
      end
      dmrtx_pkg::S_BIT: begin
        cmd.bit_step = 1'b1;
        state_nxt    = dmrtx_pkg::S_RESULT;
      end
      dmrtx_pkg::S_RESULT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = dmrtx_pkg::S_IDLE;
      end
      default: state_nxt = dmrtx_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.commit_step, cmd.load_step, cmd.bit_step}))
    else $error("conflicting commands");
`endif

endmodule
`default_nettype wire

@@ rtl/dmrtx_dp.sv @@
// dmrtx_dp: staging store, frame fifo, output buffer and bit shifter
// depends on dmrtx_pkg
`default_nettype none
module dmrtx_dp #(
  parameter int FRAME_BYTES = 33,
  parameter int FIFO_DEPTH  = 1024
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [7:0]            in_tdata_byte,
  input  wire                   in_mode,
  input  wire                   in_last,
  input  wire                   in_keyed,
  input  wire                   cfg_we,
  input  wire  [1:0]            cfg_idx,
  input  wire  [11:0]           cfg_val,
  input  dmrtx_pkg::dp_cmd_t    cmd,
  output dmrtx_pkg::dp_stat_t   stat,
  output logic                  res_kind,
  output logic [1:0]            res_status,
  output logic                  res_bit,
  output logic                  res_valid,
  output logic [4:0]            res_free
);

  localparam int FW  = $clog2(FRAME_BYTES);
  localparam int SW  = $clog2(FRAME_BYTES + 3);
  localparam int AW  = $clog2(FIFO_DEPTH);
  localparam int CW  = $clog2(FIFO_DEPTH + 1);
  localparam int FSW = (FW > 0) ? FW : 1;
  localparam int PAT_END = FRAME_BYTES + dmrtx_pkg::FILL_LEN;
  localparam int SLOT = FRAME_BYTES + 2;
  localparam int FREE_MAX = (FIFO_DEPTH / SLOT > 31) ? 31 : FIFO_DEPTH / SLOT;

  // config
  logic [11:0] pre_len_r;
  logic        cal_en_r, cal_pat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_len_r <= 12'd240;
      cal_en_r  <= 1'b0;
      cal_pat_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        dmrtx_pkg::CFG_PREAMBLE: pre_len_r <= cfg_val;
        dmrtx_pkg::CFG_CAL_EN:   cal_en_r  <= cfg_val[0];
        dmrtx_pkg::CFG_CAL_PAT:  cal_pat_r <= cfg_val[0];
        default: ;
      endcase
    end
  end

  // latched item
  logic [7:0] byte_r;
  logic       mode_r, last_r, keyed_r;
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      byte_r  <= in_tdata_byte;
      mode_r  <= in_mode;
      last_r  <= in_last;
      keyed_r <= in_keyed;
    end
  end

  // stores
  logic [7:0] stage_mem [FRAME_BYTES];
  logic [7:0] fifo_mem  [FIFO_DEPTH];
  logic [7:0] out_mem   [FRAME_BYTES];

  logic [SW-1:0]  stg_cnt_r;
  logic [AW-1:0]  rd_ptr_r, wr_ptr_r;
  logic [CW-1:0]  fcnt_r;
  logic [FSW-1:0] loop_r;      // byte loop index
  logic [11:0]    olen_r, opos_r;
  logic           pre_r;
  logic [2:0]     bidx_r;
  logic [7:0]     cur_r;
  logic [1:0]     status_r;
  logic           bit_r, valid_r;
  logic [7:0]     stg_rd_r, fifo_rd_r, out_rd_r;

  logic [CW-1:0] space;
  assign space = CW'(FIFO_DEPTH) - fcnt_r;

  // space before the commit loop began, steady while the loop fills the fifo
  logic [CW-1:0] space_start;
  assign space_start = space + CW'(loop_r);

  // loop index as an unsigned count for compare
  logic cnt_end;
  assign cnt_end = ({1'b0, loop_r} == (FSW + 1)'(FRAME_BYTES - 1));

  assign stat.mode      = mode_r;
  assign stat.last      = last_r;
  assign stat.commit_ok = (stg_cnt_r == SW'(FRAME_BYTES + 1)) &&
                          (space_start >= CW'(FRAME_BYTES));
  assign stat.need_load = (bidx_r == 3'd0) && (olen_r == 12'd0);
  assign stat.load_fifo = !cal_en_r && (fcnt_r != '0) && keyed_r;
  assign stat.cnt_end   = cnt_end;

  // staging store and fifo
  always_ff @(posedge clk) begin
    if (cmd.stage_byte && stg_cnt_r >= SW'(1) && stg_cnt_r <= SW'(FRAME_BYTES))
      stage_mem[FSW'(stg_cnt_r - SW'(1))] <= byte_r;
  end

  // the commit loop writes byte k while the loop index is k; reads are
  // pre-fetched at the next index so each step writes data read on the last edge
  logic [FSW-1:0] loop_nxt;
  always_comb begin
    loop_nxt = loop_r;
    if (cmd.stage_byte || cmd.load_start || cmd.commit_done) loop_nxt = '0;
    else if (cmd.commit_step || cmd.load_step) loop_nxt = loop_r + FSW'(1);
  end

  // staging read, prefetched at loop_nxt
  always_ff @(posedge clk) begin
    stg_rd_r <= stage_mem[loop_nxt];
  end

  // fifo: write uses staging data read at loop_r, read is registered
  always_ff @(posedge clk) begin
    if (cmd.commit_step) fifo_mem[wr_ptr_r] <= stg_rd_r;
  end
  logic [AW-1:0] rd_ptr_nxt;
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    if (cmd.load_step)
      rd_ptr_nxt = (rd_ptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
  end
  always_ff @(posedge clk) begin
    fifo_rd_r <= fifo_mem[rd_ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_step) out_mem[loop_r] <= (fcnt_r != '0) ? fifo_rd_r : 8'd0;
  end

  // out buffer read at current position
  always_ff @(posedge clk) begin
    out_rd_r <= out_mem[FSW'(opos_r)];
  end

  // byte selection
  logic [7:0]  sel_byte;
  logic [11:0] pat_idx;
  assign pat_idx = opos_r - 12'(FRAME_BYTES);
  always_comb begin
    if (pre_r) sel_byte = dmrtx_pkg::SYNC_BYTE;
    else if (opos_r < 12'(FRAME_BYTES)) sel_byte = out_rd_r;
    else if (pat_idx < 12'(dmrtx_pkg::FILL_LEN))
      sel_byte = dmrtx_pkg::FILL_PATTERN[6'(pat_idx)];
    else sel_byte = 8'd0;
  end

  logic [4:0] free_calc;
  always_comb begin
    free_calc = 5'(FREE_MAX);
    for (int k = FREE_MAX; k >= 0; k--) begin
      if (space < CW'((k + 1) * SLOT)) free_calc = 5'(k);
    end
  end

  // in calibration pattern the out buffer is filled with sync bytes: handled
  // by a cal flag held with the buffer
  logic cal_buf_r;
  always_ff @(posedge clk) begin
    if (!rst_n) cal_buf_r <= 1'b0;
    else if (cmd.load_start) cal_buf_r <= cal_en_r;
  end
  logic [7:0] eff_byte;
  assign eff_byte = (cal_buf_r && !pre_r) ? dmrtx_pkg::SYNC_BYTE : sel_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_cnt_r <= '0;
      rd_ptr_r  <= '0;
      wr_ptr_r  <= '0;
      fcnt_r    <= '0;
      loop_r    <= '0;
      olen_r    <= '0;
      opos_r    <= '0;
      pre_r     <= 1'b0;
      bidx_r    <= '0;
      cur_r     <= '0;
    end else begin
      loop_r   <= loop_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      if (cmd.stage_byte && stg_cnt_r < SW'(FRAME_BYTES + 2))
        stg_cnt_r <= stg_cnt_r + SW'(1);
      if (cmd.commit_done) stg_cnt_r <= '0;
      if (cmd.commit_step) begin
        wr_ptr_r <= (wr_ptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
        fcnt_r   <= fcnt_r + CW'(1);
      end
      if (cmd.load_step && fcnt_r != '0) fcnt_r <= fcnt_r - CW'(1);
      if (cmd.load_start) begin
        opos_r <= '0;
        if (cal_en_r) begin
          pre_r <= 1'b0;
          if (cal_pat_r) olen_r <= 12'(FRAME_BYTES);
        end else if (fcnt_r != '0) begin
          // nothing queued leaves the output idle
          if (!keyed_r) begin
            pre_r  <= 1'b1;
            olen_r <= pre_len_r;
          end else begin
            pre_r  <= 1'b0;
            olen_r <= 12'(PAT_END);
          end
        end
      end
      if (cmd.bit_step) begin
        if (bidx_r == 3'd0) begin
          if (olen_r != '0) begin
            cur_r  <= eff_byte;
            bidx_r <= 3'd1;
            if (opos_r + 12'd1 >= olen_r) begin
              opos_r <= '0;
              olen_r <= '0;
              pre_r  <= 1'b0;
            end else begin
              opos_r <= opos_r + 12'd1;
            end
          end
        end else begin
          bidx_r <= bidx_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_status)
      status_r <= !(stg_cnt_r == SW'(FRAME_BYTES + 1)) ? dmrtx_pkg::ST_LEN :
                  (space_start < CW'(FRAME_BYTES)) ? dmrtx_pkg::ST_SPACE :
                  dmrtx_pkg::ST_OK;
    if (cmd.bit_step) begin
      if (bidx_r == 3'd0) begin
        bit_r   <= (olen_r != '0) ? eff_byte[7] : 1'b0;
        valid_r <= (olen_r != '0);
      end else begin
        bit_r   <= cur_r[3'd7 - bidx_r];
        valid_r <= 1'b1;
      end
    end
  end

  assign res_kind   = mode_r;
  assign res_status = mode_r ? 2'd0 : status_r;
  assign res_bit    = mode_r & bit_r;
  assign res_valid  = mode_r & valid_r;
  assign res_free   = free_calc;

`ifndef SYNTH
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= CW'(FIFO_DEPTH)) else $error("fifo count overflow");
  a_stg: assert property (@(posedge clk) disable iff (!rst_n)
    stg_cnt_r <= SW'(FRAME_BYTES + 2)) else $error("staging count overflow");
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    olen_r != '0 |-> opos_r < olen_r) else $error("position past length");
`endif

endmodule
`default_nettype wire

@@ rtl/dmr_direct_mode_tx_framer.sv @@
// dmr_direct_mode_tx_framer: top level of the direct mode transmit framer
// depends on dmrtx_pkg, dmrtx_ctrl, dmrtx_dp
//
// channel  dir  contents
// in_*     in   tdata {data_byte}, tuser {tx_active, mode}, tlast frame_last
// out_*    out  tdata {free_frames, bit_valid, tx_bit, write_status}, tuser result_kind
// cfg_*    in   write enable, register index, 12 bit data
//
// one transfer at a time; a bit request passes the load and bit states, and
// also the byte-per-cycle fifo loop when a frame is loaded into the out buffer
// a final frame byte runs the byte-per-cycle commit loop, which ends at once
// when the frame is rejected; other frame bytes are staged and give no result
// synchronous active low reset clears pointers, counts and control state and sets config defaults
// an output stall holds the result and blocks new input
`default_nettype none
module dmr_direct_mode_tx_framer #(
  parameter int FRAME_BYTES = 33,
  parameter int FIFO_DEPTH  = 1024
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // data_byte
  input  wire  [1:0]  in_tuser,   // tx_active, mode
  input  wire         in_tlast,
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // free_frames, bit_valid, tx_bit, write_status
  output logic        out_tuser,  // result_kind
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_idx,
  input  wire  [11:0] cfg_data
);

  dmrtx_pkg::dp_cmd_t  cmd;
  dmrtx_pkg::dp_stat_t stat;
  logic       r_kind, r_bit, r_valid;
  logic [1:0] r_status;
  logic [4:0] r_free;

  dmrtx_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .stat, .cmd
  );

  dmrtx_dp #(.FRAME_BYTES(FRAME_BYTES), .FIFO_DEPTH(FIFO_DEPTH)) u_dp (
    .clk, .rst_n,
    .in_tdata_byte (in_tdata),
    .in_mode       (in_tuser[0]),
    .in_last       (in_tlast),
    .in_keyed      (in_tuser[1]),
    .cfg_we, .cfg_idx, .cfg_val(cfg_data),
    .cmd, .stat,
    .res_kind(r_kind), .res_status(r_status), .res_bit(r_bit),
    .res_valid(r_valid), .res_free(r_free)
  );

  assign out_tdata = {7'd0, r_free, r_valid, r_bit, r_status};
  assign out_tuser = r_kind;

endmodule
`default_nettype wire

@@ sim/tb_dmr_direct_mode_tx_framer.sv @@
// tb_dmr_direct_mode_tx_framer: self-checking bench for the direct mode transmit framer
// predicts results from a framer state copy or the directed table, checks field by field
// depends on dmrtx_pkg and dmr_direct_mode_tx_framer
`default_nettype none
module tb_dmr_direct_mode_tx_framer;

  localparam int NBYTES   = 33;
  localparam int DEPTH    = 1024;
  localparam int WD_LIMIT = 5000;

  // one result as seen on the out channel
  typedef struct {
    logic                  kind;
    dmrtx_pkg::wr_status_t status;
    logic                  tx_bit;
    logic                  valid;
    logic [4:0]            free;
  } result_t;

  // one row of the directed table
  typedef struct {
    logic       mode;
    logic [7:0] data;
    logic       last;
    logic       keyed;
    logic       typed;
    result_t    res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;  // data_byte
  logic [1:0]  in_tuser = '0;  // tx_active, mode
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;      // free_frames, bit_valid, tx_bit, write_status
  logic        out_tuser;      // result_kind
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [11:0] cfg_data = '0;

  always #5 clk = ~clk;

  dmr_direct_mode_tx_framer u_top (.*);

  // ---------------- framer state mirror ----------------
  logic [7:0]  fifo_mem [DEPTH];
  int          fifo_rd, fifo_wr, fifo_cnt;
  logic [7:0]  stage_mem [NBYTES];
  int          stage_cnt;
  logic [7:0]  txbuf [NBYTES];
  int          tx_len, tx_pos;
  logic        in_preamble;
  int          bit_pos;
  logic [7:0]  shift_byte;
  int          preamble_len;
  logic        cal_on, cal_pattern;

  result_t     pending_results [$];
  bit          failed = 1'b0;
  bit          row_typed = 1'b0;  // current transfer carries a typed expectation
  result_t     row_res;
  bit          quiet_in = 1'b0, quiet_out = 1'b0;
  int          idle_cycles = 0;

  function automatic logic [4:0] free_slots();
    int f;
    f = (DEPTH - fifo_cnt) / (NBYTES + 2);
    return (f > 31) ? 5'd31 : 5'(f);
  endfunction

  function automatic logic [7:0] fifo_pop();
    logic [7:0] b;
    if (fifo_cnt == 0) return 8'h00;  // empty read gives zero, pointers stay
    b = fifo_mem[fifo_rd];
    fifo_rd = (fifo_rd + 1) % DEPTH;
    fifo_cnt--;
    return b;
  endfunction

  // advance the mirror by one accepted item; returns 1 when a result follows
  function automatic bit framer_step(input logic mode, input logic [7:0] data,
                                     input logic last, input logic keyed,
                                     output result_t r);
    r = '{kind: mode, status: dmrtx_pkg::ST_OK, tx_bit: 1'b0, valid: 1'b0, free: 5'd0};
    if (!mode) begin
      if (stage_cnt >= 1 && stage_cnt <= NBYTES) stage_mem[stage_cnt - 1] = data;
      if (stage_cnt < NBYTES + 2) stage_cnt++;  // count saturates on overlong frames
      if (!last) return 1'b0;
      if (stage_cnt != NBYTES + 1) r.status = dmrtx_pkg::ST_LEN;
      else if (DEPTH - fifo_cnt < NBYTES) r.status = dmrtx_pkg::ST_SPACE;
      else begin
        for (int i = 0; i < NBYTES; i++) begin
          fifo_mem[fifo_wr] = stage_mem[i];
          fifo_wr = (fifo_wr + 1) % DEPTH;
          fifo_cnt++;
        end
      end
      stage_cnt = 0;
    end else if (bit_pos == 0) begin
      // byte boundary: pick the next buffer when the current one is done
      if (tx_len == 0) begin
        if (cal_on) begin
          in_preamble = 1'b0;
          if (cal_pattern) begin
            for (int i = 0; i < NBYTES; i++) txbuf[i] = dmrtx_pkg::SYNC_BYTE;
            tx_len = NBYTES;
          end
          tx_pos = 0;
        end else if (fifo_cnt > 0) begin
          if (!keyed) begin
            in_preamble = 1'b1;
            tx_len = preamble_len;
          end else begin
            in_preamble = 1'b0;
            for (int i = 0; i < NBYTES; i++) txbuf[i] = fifo_pop();
            tx_len = NBYTES + dmrtx_pkg::FILL_LEN;
          end
          tx_pos = 0;
        end
      end
      if (tx_len > 0) begin
        if (in_preamble) shift_byte = dmrtx_pkg::SYNC_BYTE;
        else if (tx_pos < NBYTES) shift_byte = txbuf[tx_pos];
        else shift_byte = dmrtx_pkg::FILL_PATTERN[tx_pos - NBYTES];
        tx_pos++;
        if (tx_pos >= tx_len) begin
          tx_pos = 0;
          tx_len = 0;
          in_preamble = 1'b0;
        end
        r.tx_bit = shift_byte[7];
        r.valid = 1'b1;
        bit_pos = 1;
      end
    end else begin
      r.tx_bit = shift_byte[7 - bit_pos];
      r.valid = 1'b1;
      bit_pos = (bit_pos + 1) % 8;
    end
    r.free = free_slots();
    return 1'b1;
  endfunction

  // ---------------- input side: predict on every transfer ----------------
  always @(posedge clk) begin
    result_t r;
    if (rst_n && in_tvalid && in_tready) begin
      if (framer_step(in_tuser[0], in_tdata, in_tlast, in_tuser[1], r))
        pending_results.push_back(row_typed ? row_res : r);
    end
  end

  // ---------------- output side: compare with the oldest expectation ----------------
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: tdata %h tuser %b", out_tdata, out_tuser);
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        if (out_tuser !== e.kind) begin
          $error("result_kind: expected %0d, got %0d", e.kind, out_tuser);
          failed = 1'b1;
        end
        if (out_tdata[1:0] !== e.status) begin
          $error("write_status: expected %0d, got %0d", e.status, out_tdata[1:0]);
          failed = 1'b1;
        end
        if (out_tdata[2] !== e.tx_bit) begin
          $error("tx_bit: expected %0d, got %0d", e.tx_bit, out_tdata[2]);
          failed = 1'b1;
        end
        if (out_tdata[3] !== e.valid) begin
          $error("bit_valid: expected %0d, got %0d", e.valid, out_tdata[3]);
          failed = 1'b1;
        end
        if (out_tdata[8:4] !== e.free) begin
          $error("free_frames: expected %0d, got %0d", e.free, out_tdata[8:4]);
          failed = 1'b1;
        end
        if (out_tdata[15:9] !== '0) begin
          $error("tdata padding: expected 0, got %h", out_tdata[15:9]);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog: cycles without any transfer or register write
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result sink with random stalls, some stretches without any
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) quiet_out = ~quiet_out;
      stall = quiet_out ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // ---------------- stimulus helpers ----------------
  // one input transfer; called and returns at a falling edge
  task automatic push_item(input logic mode, input logic [7:0] data, input logic last,
                           input logic keyed, input bit typed = 1'b0,
                           input result_t tres = '{kind: 1'b0, status: dmrtx_pkg::ST_OK,
                                                   tx_bit: 1'b0, valid: 1'b0, free: 5'd0});
    int gap;
    if ($urandom_range(0, 39) == 0) quiet_in = ~quiet_in;
    gap = quiet_in ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    row_typed = typed;
    row_res   = tres;
    in_tdata  <= data;
    in_tuser  <= {keyed, mode};
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // block idle: all results back, then let a frame commit drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic reg_write(input dmrtx_pkg::cfg_idx_t idx, input logic [11:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dmrtx_pkg::CFG_PREAMBLE: preamble_len = int'(val);
      dmrtx_pkg::CFG_CAL_EN:   cal_on = val[0];
      dmrtx_pkg::CFG_CAL_PAT:  cal_pattern = val[0];
      default: ;
    endcase
  endtask

  // header plus len-1 payload bytes, last flag on the final byte
  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++)
      push_item(1'b0, 8'($urandom), i == len - 1, 1'($urandom));
  endtask

  task automatic send_bits(input int n, input logic keyed);
    for (int i = 0; i < n; i++)
      push_item(1'b1, 8'($urandom), 1'($urandom), keyed);
  endtask

  // mostly well-formed frames and bit bursts, some broken frames
  task automatic random_traffic(input int n_items, input bit keyed_only);
    int sent, len, pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        send_frame(NBYTES + 1);
        sent += NBYTES + 1;
      end else if (pick == 4) begin
        len = $urandom_range(1, NBYTES + 8);
        send_frame(len);
        sent += len;
      end else begin
        len = $urandom_range(8, 120);
        send_bits(len, keyed_only ? 1'b1 : ($urandom_range(0, 4) != 0));
        sent += len;
      end
    end
  endtask

  // ---------------- main sequence ----------------
  initial begin
    row_t    dir_rows [$];
    row_t    row;
    result_t idle_bit, len_err;

    fifo_rd = 0; fifo_wr = 0; fifo_cnt = 0; stage_cnt = 0;
    tx_len = 0; tx_pos = 0; in_preamble = 1'b0; bit_pos = 0; shift_byte = '0;
    preamble_len = 240; cal_on = 1'b0; cal_pattern = 1'b0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table: empty fifo idles, short and overlong frames, one good frame,
    // then bit requests through the default preamble
    idle_bit = '{kind: 1'b1, status: dmrtx_pkg::ST_OK, tx_bit: 1'b0, valid: 1'b0,
                 free: 5'd29};
    len_err  = '{kind: 1'b0, status: dmrtx_pkg::ST_LEN, tx_bit: 1'b0, valid: 1'b0,
                 free: 5'd29};
    dir_rows.push_back('{1'b1, 8'hFF, 1'b1, 1'b0, 1'b1, idle_bit});
    dir_rows.push_back('{1'b1, 8'h00, 1'b0, 1'b1, 1'b1, idle_bit});
    dir_rows.push_back('{1'b0, 8'hFF, 1'b1, 1'b1, 1'b1, len_err});   // header only
    dir_rows.push_back('{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, idle_bit});
    dir_rows.push_back('{1'b0, 8'hFF, 1'b1, 1'b0, 1'b1, len_err});   // two bytes
    // correct length frame, payload alternates even indices and 0xFF
    for (int i = 0; i <= NBYTES; i++) begin
      row = '{1'b0, (i % 2) ? 8'hFF : 8'(i), i == NBYTES, 1'b0, 1'b0, idle_bit};
      dir_rows.push_back(row);
    end
    // overlong frame: count saturates, length error
    for (int i = 0; i < NBYTES + 4; i++) begin
      row = '{1'b0, 8'h80, i == NBYTES + 3, 1'b1, 1'b0, idle_bit};
      dir_rows.push_back(row);
    end
    // unkeyed bit requests start the sync preamble
    for (int i = 0; i < 10; i++) dir_rows.push_back('{1'b1, 8'hA5, 1'b0, 1'b0, 1'b0, idle_bit});

    foreach (dir_rows[i])
      push_item(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].last, dir_rows[i].keyed,
                dir_rows[i].typed, dir_rows[i].res);

    random_traffic(120, 1'b0);

    // zero preamble: unkeyed requests idle
    settle();
    reg_write(dmrtx_pkg::CFG_PREAMBLE, 12'd0);
    reg_write(dmrtx_pkg::CFG_CAL_EN, 12'd0);
    reg_write(dmrtx_pkg::CFG_CAL_PAT, 12'd0);
    random_traffic(80, 1'b0);

    // one byte preamble
    settle();
    reg_write(dmrtx_pkg::CFG_PREAMBLE, 12'd1);
    random_traffic(80, 1'b0);

    // keyed requests send queued frames and their fill pattern
    settle();
    reg_write(dmrtx_pkg::CFG_PREAMBLE, 12'd2);
    send_bits(100, 1'b1);

    // long preamble, only keyed requests so frames go straight out
    settle();
    reg_write(dmrtx_pkg::CFG_PREAMBLE, 12'd3660);
    random_traffic(80, 1'b1);

    // calibration with the deviation pattern
    settle();
    reg_write(dmrtx_pkg::CFG_CAL_EN, 12'd1);
    reg_write(dmrtx_pkg::CFG_CAL_PAT, 12'd1);
    random_traffic(80, 1'b0);

    // calibration idle once the current buffer ends
    settle();
    reg_write(dmrtx_pkg::CFG_CAL_PAT, 12'd0);
    random_traffic(50, 1'b0);

    // back to normal with the reset preamble length
    settle();
    reg_write(dmrtx_pkg::CFG_CAL_EN, 12'd0);
    reg_write(dmrtx_pkg::CFG_PREAMBLE, 12'd240);
    random_traffic(80, 1'b0);

    settle();
    if (!failed && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ dmr_direct_mode_tx_framer.f @@
rtl/dmrtx_pkg.sv
rtl/dmrtx_ctrl.sv
rtl/dmrtx_dp.sv
rtl/dmr_direct_mode_tx_framer.sv
sim/tb_dmr_direct_mode_tx_framer.sv
